@@ hw/rtl/rbsi_pkg.sv @@
package rbsi_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned NUM_W = QW + 1;
  localparam int unsigned EPS_W = 17;
  localparam int unsigned DIV_STEPS = QW;
  // magnitude stage, setup stage, one stage per quotient bit, saturation stage
  localparam int unsigned DIV_LAT = DIV_STEPS + 3;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_LANES = 2 * NUM_AXES;

  localparam logic [QW-1:0] T_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] T_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [NUM_AXES-1:0] par;
    logic                par_miss;
  } side_t;

endpackage

@@ hw/rtl/rbsi_div_lane.sv @@
module rbsi_div_lane import rbsi_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [QW-1:0]    den_i,
  output logic [QW-1:0]    quo_o
);

  localparam int unsigned NW = QW + FracBits + 1;
  localparam int unsigned HW = NW - QW;

  logic          neg_a_q;
  logic [QW-1:0] nmag_a_q;
  logic [QW-1:0] dmag_a_q;

  logic [QW-1:0] rem_q  [DIV_STEPS+1];
  logic [QW-1:0] low_q  [DIV_STEPS+1];
  logic [QW-1:0] quo_q  [DIV_STEPS+1];
  logic [QW-1:0] dmag_q [DIV_STEPS+1];
  logic          neg_q  [DIV_STEPS+1];
  logic          ovf_q  [DIV_STEPS+1];

  logic [NUM_W-1:0] num_neg;
  logic [QW-1:0]    den_neg;
  logic [NW-1:0]    n_full;
  logic [HW-1:0]    n_hi;
  logic [QW-1:0]    quo_d;

  assign num_neg = -num_i;
  assign den_neg = -den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q  <= num_i[NUM_W-1] ^ den_i[QW-1];
      nmag_a_q <= num_i[NUM_W-1] ? num_neg[QW-1:0] : num_i[QW-1:0];
      dmag_a_q <= den_i[QW-1] ? den_neg : den_i;
    end
  end

  // Bits above the quotient window: if they already reach the divisor the quotient overflows.
  assign n_full = NW'(nmag_a_q) << FracBits;
  assign n_hi   = n_full[NW-1:QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= NUM_W'(n_hi) >= {1'b0, dmag_a_q};
      rem_q[0]  <= QW'(n_hi);
      low_q[0]  <= n_full[QW-1:0];
      quo_q[0]  <= '0;
      dmag_q[0] <= dmag_a_q;
      neg_q[0]  <= neg_a_q;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0] trial;
    logic [NUM_W-1:0] diff;
    logic             take;

    assign trial = {rem_q[k], low_q[k][QW-1]};
    assign diff  = trial - {1'b0, dmag_q[k]};
    assign take  = trial >= {1'b0, dmag_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? diff[QW-1:0] : trial[QW-1:0];
        low_q[k+1]  <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][QW-2:0], take};
        dmag_q[k+1] <= dmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  always_comb begin
    if (neg_q[DIV_STEPS]) begin
      if (ovf_q[DIV_STEPS] || (quo_q[DIV_STEPS] > T_MIN)) begin
        quo_d = T_MIN;
      end else begin
        quo_d = -quo_q[DIV_STEPS];
      end
    end else begin
      if (ovf_q[DIV_STEPS] || quo_q[DIV_STEPS][QW-1]) begin
        quo_d = T_MAX;
      end else begin
        quo_d = quo_q[DIV_STEPS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_d;
    end
  end

endmodule

@@ hw/rtl/rbsi_merge.sv @@
module rbsi_merge import rbsi_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [NUM_LANES-1:0][QW-1:0]  t_i,
  input  side_t                         side_i,
  output logic                          hit_o,
  output logic [QW-2:0]                 dist_o
);

  logic [NUM_AXES-1:0][QW-1:0] lo_q, hi_q;
  logic                        miss_q;

  // Order each axis pair; parallel axes leave the interval open.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (side_i.par[a]) begin
          lo_q[a] <= '0;
          hi_q[a] <= T_MAX;
        end else if ($signed(t_i[a]) > $signed(t_i[NUM_AXES+a])) begin
          lo_q[a] <= t_i[NUM_AXES+a];
          hi_q[a] <= t_i[a];
        end else begin
          lo_q[a] <= t_i[a];
          hi_q[a] <= t_i[NUM_AXES+a];
        end
      end
      miss_q <= side_i.par_miss;
    end
  end

  logic [QW-1:0] lo_max, hi_min;
  logic          hit_d;

  always_comb begin
    lo_max = '0;
    hi_min = T_MAX;
    for (int a = 0; a < NUM_AXES; a++) begin
      if ($signed(lo_q[a]) > $signed(lo_max)) lo_max = lo_q[a];
      if ($signed(hi_q[a]) < $signed(hi_min)) hi_min = hi_q[a];
    end
    hit_d = !miss_q && ($signed(lo_max) <= $signed(hi_min));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o  <= hit_d;
      dist_o <= hit_d ? lo_max[QW-2:0] : '0;
    end
  end

endmodule

@@ hw/rtl/ray_box_slab_intersect_unit.sv @@
// Input register, six 35-stage pipelined dividers (one quotient bit a stage), merge stages.
// Throughput: one word per cycle while the output is not stalled.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous): valid bits clear and dir_epsilon returns to 1.
module ray_box_slab_intersect_unit import rbsi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [EPS_W-1:0]       cfg_wdata_i,      // dir_epsilon
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32 bits each)
  input  logic [12*QW-1:0]       s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [QW-1:0]          m_axis_tdata_o    // hit [0], entry_distance [31:1]
);

  localparam int unsigned NSTG = DIV_LAT + 3;

  logic             en;
  logic [EPS_W-1:0] eps_q;
  logic [NSTG-1:0]  vld_q;

  // Advance everything whenever the output slot is free or being drained.
  assign en              = !vld_q[NSTG-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid_i};
    end
  end

  // Input register: hold the raw word.
  logic [12*QW-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= s_axis_tdata_i;
    end
  end

  logic [NUM_AXES-1:0][QW-1:0] org, dir, bmin, bmax;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_unpack
    assign org[a]  = in_q[a*QW +: QW];
    assign dir[a]  = in_q[(3+a)*QW +: QW];
    assign bmin[a] = in_q[(6+a)*QW +: QW];
    assign bmax[a] = in_q[(9+a)*QW +: QW];
  end

  // Slab classification: a zero or tiny direction is parallel, and then the
  // origin must lie within the slab (points on a face count as inside).
  side_t                       side_d;
  logic [NUM_AXES-1:0]         outside;
  logic [NUM_AXES-1:0][QW-1:0] dmag;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dmag[a]       = dir[a][QW-1] ? -dir[a] : dir[a];
      side_d.par[a] = (dir[a] == '0) || (dmag[a] < QW'(eps_q));
      outside[a]    = ($signed(org[a]) < $signed(bmin[a]))
                   || ($signed(org[a]) > $signed(bmax[a]));
    end
    side_d.par_miss = |(side_d.par & outside);
  end

  // Sideband follows the dividers stage for stage.
  side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int s = 1; s < DIV_LAT; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Six dividers: lanes 0..2 use the minimum corner, lanes 3..5 the maximum.
  logic [NUM_LANES-1:0][QW-1:0] t_div;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic [NUM_W-1:0] num_lo, num_hi;

    assign num_lo = {bmin[a][QW-1], bmin[a]} - {org[a][QW-1], org[a]};
    assign num_hi = {bmax[a][QW-1], bmax[a]} - {org[a][QW-1], org[a]};

    rbsi_div_lane #(.FracBits(FRAC_BITS)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_lo),
      .den_i (dir[a]),
      .quo_o (t_div[a])
    );

    rbsi_div_lane #(.FracBits(FRAC_BITS)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_hi),
      .den_i (dir[a]),
      .quo_o (t_div[NUM_AXES+a])
    );
  end

  logic          hit;
  logic [QW-2:0] entry_dist;

  rbsi_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .t_i    (t_div),
    .side_i (side_q[DIV_LAT-1]),
    .hit_o  (hit),
    .dist_o (entry_dist)
  );

  assign m_axis_tdata_o = {entry_dist, hit};

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[QW-1:1] == '0)
    else $error("miss word carries a non-zero distance");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_arrive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[NSTG-2] |=> m_axis_tvalid_o)
    else $error("word lost before the output register");
`endif

endmodule
